// ===== src/fqmtf_pkg.sv =====
// Shared types, constants and helpers for the FIFO queue with move-to-front.
// No dependencies; imported by the top level and the testbench.
package fqmtf_pkg;

    localparam int DEPTH      = 16;
    localparam int DATA_WIDTH = 32;
    localparam int PTR_W      = $clog2(DEPTH);
    localparam int CNT_W      = $clog2(DEPTH + 1);

    localparam int OPCODE_W = 2;
    localparam int VALUE_W  = 32;
    localparam int FRONT_W  = 32;
    localparam int COUNT_W  = 5;
    localparam int STATUS_W = 2;

    localparam logic [OPCODE_W-1:0] OP_ENQ = 2'd0;
    localparam logic [OPCODE_W-1:0] OP_DEQ = 2'd1;
    localparam logic [OPCODE_W-1:0] OP_MTF = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_DEQ_EMPTY = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_ENQ_FULL  = 2'd2;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic [VALUE_W-1:0]  value;
    } in_beat_t;

    typedef struct packed {
        logic [FRONT_W-1:0]  front_value;
        logic                is_empty;
        logic [COUNT_W-1:0]  entry_count;
        logic [STATUS_W-1:0] status;
    } out_beat_t;

    // logical position -> physical slot in the circular store
    function automatic logic [PTR_W-1:0] phys_slot(input logic [PTR_W-1:0] head,
                                                    input logic [PTR_W-1:0] idx);
        logic [PTR_W:0] sum;
        sum = {1'b0, head} + {1'b0, idx};
        if (sum >= (PTR_W + 1)'(DEPTH)) begin
            sum = sum - (PTR_W + 1)'(DEPTH);
        end
        return sum[PTR_W-1:0];
    endfunction

    function automatic out_beat_t make_result(input logic [DATA_WIDTH-1:0] front,
                                              input logic [CNT_W-1:0]      count,
                                              input logic [STATUS_W-1:0]   status);
        out_beat_t r;
        r.front_value = (count == '0) ? '0 : FRONT_W'(front);
        r.is_empty    = (count == '0);
        r.entry_count = COUNT_W'(count);
        r.status      = status;
        return r;
    endfunction

endpackage

// ===== src/fqmtf_ram.sv =====
// Generic simple dual-port RAM: one write port, one read port, registered read.
// No dependencies.
module fqmtf_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== src/fifo_queue_with_move_to_front.sv =====
// FIFO queue with move-to-front, entries held in a circular RAM (fqmtf_ram).
// An enqueue, a dequeue that empties or misses, and a move with nothing to do register
// their result straight from the beat; any other dequeue re-reads the front from RAM.
// Move-to-front over n entries: a miss searches entries 1 to n-1, a match at position i
// does i search reads, i shift writes and 1 head write. One beat in flight at a time.
// Reset (aresetn low, synchronous) empties the queue; RAM contents are left as they are.
module fifo_queue_with_move_to_front
    import fqmtf_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_beat_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_beat_t m_data
);

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FRONT,
        ST_SEARCH,
        ST_SHIFT,
        ST_PLACE
    } state_t;

    state_t                 state_reg;
    logic [CNT_W-1:0]       count_reg;
    logic [PTR_W-1:0]       head_reg;
    logic [PTR_W-1:0]       idx_reg;
    logic [DATA_WIDTH-1:0]  front_reg;
    logic [DATA_WIDTH-1:0]  key_reg;
    logic                   m_valid_reg;
    out_beat_t              m_data_reg;

    logic                   s_beat;
    logic [DATA_WIDTH-1:0]  key;
    logic                   ram_we;
    logic [PTR_W-1:0]       ram_waddr;
    logic [DATA_WIDTH-1:0]  ram_wdata;
    logic [PTR_W-1:0]       ram_raddr;
    logic [DATA_WIDTH-1:0]  ram_rdata;
    logic                   hit;
    logic                   last_idx;

    assign s_ready  = (state_reg == ST_IDLE) && (!m_valid_reg || m_ready);
    assign s_beat   = s_valid && s_ready;
    assign key      = DATA_WIDTH'(s_data.value);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign hit      = (ram_rdata == key_reg);
    assign last_idx = (CNT_W'(idx_reg) == count_reg - CNT_W'(1));

    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = head_reg;
        ram_wdata = key_reg;
        ram_raddr = phys_slot(head_reg, PTR_W'(1));
        case (state_reg)
            ST_IDLE: begin
                ram_we    = s_beat && (s_data.opcode == OP_ENQ) &&
                            (count_reg != CNT_W'(DEPTH));
                ram_waddr = phys_slot(head_reg, count_reg[PTR_W-1:0]);
                ram_wdata = key;
            end
            ST_SEARCH: begin
                // on a hit, start fetching the entry just ahead of the match
                ram_raddr = hit ? phys_slot(head_reg, idx_reg - PTR_W'(1))
                                : phys_slot(head_reg, idx_reg + PTR_W'(1));
            end
            ST_SHIFT: begin
                ram_we    = 1'b1;
                ram_waddr = phys_slot(head_reg, idx_reg);
                ram_wdata = ram_rdata;
                ram_raddr = (idx_reg >= PTR_W'(2)) ? phys_slot(head_reg, idx_reg - PTR_W'(2))
                                                    : head_reg;
            end
            ST_PLACE: begin
                ram_we    = 1'b1;
                ram_waddr = head_reg;
                ram_wdata = key_reg;
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    fqmtf_ram #(
        .WIDTH(DATA_WIDTH),
        .DEPTH(DEPTH)
    ) u_ram (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            head_reg    <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            // an accepted input beat settles m_valid_reg in its own arm below
            if (m_valid_reg && m_ready && !s_beat) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE: begin
                    if (s_beat) begin
                        key_reg <= key;
                        idx_reg <= PTR_W'(1);
                        case (s_data.opcode)
                            OP_ENQ: begin
                                m_valid_reg <= 1'b1;
                                if (count_reg == CNT_W'(DEPTH)) begin
                                    m_data_reg <= make_result(front_reg, count_reg,
                                                              STAT_ENQ_FULL);
                                end else begin
                                    count_reg <= count_reg + CNT_W'(1);
                                    if (count_reg == '0) begin
                                        front_reg <= key;
                                    end
                                    m_data_reg <= make_result(
                                        (count_reg == '0) ? key : front_reg,
                                        count_reg + CNT_W'(1), STAT_OK);
                                end
                            end
                            OP_DEQ: begin
                                if (count_reg == '0) begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= make_result(front_reg, count_reg,
                                                               STAT_DEQ_EMPTY);
                                end else begin
                                    count_reg <= count_reg - CNT_W'(1);
                                    head_reg  <= phys_slot(head_reg, PTR_W'(1));
                                    if (count_reg == CNT_W'(1)) begin
                                        m_valid_reg <= 1'b1;
                                        m_data_reg  <= make_result(front_reg, '0, STAT_OK);
                                    end else begin
                                        m_valid_reg <= 1'b0;
                                        state_reg   <= ST_FRONT;
                                    end
                                end
                            end
                            OP_MTF: begin
                                // nothing to move when empty, single entry or hit at head
                                if (count_reg >= CNT_W'(2) && front_reg != key) begin
                                    m_valid_reg <= 1'b0;
                                    state_reg   <= ST_SEARCH;
                                end else begin
                                    m_valid_reg <= 1'b1;
                                    m_data_reg  <= make_result(front_reg, count_reg, STAT_OK);
                                end
                            end
                            default: begin
                                m_valid_reg <= 1'b1;
                                m_data_reg  <= make_result(front_reg, count_reg, STAT_OK);
                            end
                        endcase
                    end
                end
                ST_FRONT: begin
                    front_reg   <= ram_rdata;
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= make_result(ram_rdata, count_reg, STAT_OK);
                    state_reg   <= ST_IDLE;
                end
                ST_SEARCH: begin
                    if (hit) begin
                        state_reg <= ST_SHIFT;
                    end else if (last_idx) begin
                        m_valid_reg <= 1'b1;
                        m_data_reg  <= make_result(front_reg, count_reg, STAT_OK);
                        state_reg   <= ST_IDLE;
                    end else begin
                        idx_reg <= idx_reg + PTR_W'(1);
                    end
                end
                ST_SHIFT: begin
                    // entry idx-1 moves down to idx, walking towards the head
                    if (idx_reg == PTR_W'(1)) begin
                        state_reg <= ST_PLACE;
                    end else begin
                        idx_reg <= idx_reg - PTR_W'(1);
                    end
                end
                ST_PLACE: begin
                    front_reg   <= key_reg;
                    m_valid_reg <= 1'b1;
                    m_data_reg  <= make_result(key_reg, count_reg, STAT_OK);
                    state_reg   <= ST_IDLE;
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CNT_W'(DEPTH))
        else $error("occupancy beyond capacity");

    a_busy_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !m_valid_reg)
        else $error("result pending while an operation is still in progress");

    a_count_on_beat: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_beat |=> $stable(count_reg))
        else $error("occupancy changed without an input beat");

    a_empty_flags: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.is_empty == (m_data_reg.entry_count == '0)))
        else $error("empty flag disagrees with entry count");

    a_empty_front: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_data_reg.is_empty) |-> (m_data_reg.front_value == '0))
        else $error("non-zero front value on empty queue");

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// Self-checking bench for fifo_queue_with_move_to_front: a directed table, then random
// enqueue, dequeue and move-to-front traffic with stalls on both sides, against a queue model.
// Depends on fqmtf_pkg and the top level in src/.
module tb_top;
    import fqmtf_pkg::*;

    localparam logic [OPCODE_W-1:0] OP_UNUSED = 2'd3;

    localparam int CLK_HALF      = 5;
    localparam int RESET_CYCLES  = 7;
    localparam int RANDOM_ITEMS  = 1600;
    localparam int CYCLE_LIMIT   = 1_000_000;
    localparam int SETTLE_CYCLES = 40;
    localparam int REPORT_CAP    = 100;
    localparam int NUM_DIRECTED  = 26;

    typedef struct packed {
        in_beat_t  beat;
        logic      has_known;
        out_beat_t known;
    } dir_row_t;

    typedef struct packed {
        logic      has_known;
        out_beat_t known;
    } beat_note_t;

    localparam out_beat_t NO_CHECK = '0;
    localparam out_beat_t EMPTY_OK = '{front_value: '0, is_empty: 1'b1,
                                       entry_count: '0, status: STAT_OK};

    // Rows with has_known clear are checked against the queue model only.
    localparam dir_row_t DIRECTED [NUM_DIRECTED] = '{
        '{'{OP_DEQ,    32'h0000_0000}, 1'b1, '{32'h0, 1'b1, 5'd0, STAT_DEQ_EMPTY}},
        '{'{OP_MTF,    32'h0000_0000}, 1'b1, EMPTY_OK},
        '{'{OP_UNUSED, 32'hffff_ffff}, 1'b1, EMPTY_OK},
        '{'{OP_ENQ,    32'hffff_ffff}, 1'b1, '{32'hffff_ffff, 1'b0, 5'd1, STAT_OK}},
        '{'{OP_ENQ,    32'h0000_0000}, 1'b0, NO_CHECK},
        '{'{OP_MTF,    32'h0000_0000}, 1'b0, NO_CHECK},
        '{'{OP_MTF,    32'h0000_0000}, 1'b0, NO_CHECK},
        '{'{OP_MTF,    32'h1234_5678}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'ha5a5_a5a5}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h5a5a_5a5a}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'ha5a5_a5a5}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0000_0001}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h8000_0000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h7fff_ffff}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'hffff_ffff}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0000_0010}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0000_0100}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0000_1000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0001_0000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0010_0000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h0100_0000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'h1000_0000}, 1'b0, NO_CHECK},
        '{'{OP_ENQ,    32'hcafe_f00d}, 1'b1, '{32'h0, 1'b0, 5'd16, STAT_ENQ_FULL}},
        '{'{OP_MTF,    32'h1000_0000}, 1'b0, NO_CHECK},
        '{'{OP_MTF,    32'ha5a5_a5a5}, 1'b0, NO_CHECK},
        '{'{OP_DEQ,    32'hffff_ffff}, 1'b0, NO_CHECK}
    };

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_beat_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_beat_t m_data;

    logic [DATA_WIDTH-1:0] held_words [$];
    out_beat_t             pending_results [$];
    beat_note_t            sent_notes [$];
    logic [DATA_WIDTH-1:0] word_pool [8];
    int unsigned           mismatches  = 0;
    int unsigned           cycle_count = 0;

    fifo_queue_with_move_to_front u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #CLK_HALF aclk = ~aclk;

    // Queue model: slot 0 is the head.
    function automatic out_beat_t apply_queue_op(input in_beat_t beat);
        out_beat_t             r;
        logic [DATA_WIDTH-1:0] hit;
        int                    pos;
        r.status = STAT_OK;
        pos = -1;
        case (beat.opcode)
            OP_ENQ: begin
                if (held_words.size() >= DEPTH) begin
                    r.status = STAT_ENQ_FULL;
                end else begin
                    held_words.push_back(DATA_WIDTH'(beat.value));
                end
            end
            OP_DEQ: begin
                if (held_words.size() == 0) begin
                    r.status = STAT_DEQ_EMPTY;
                end else begin
                    void'(held_words.pop_front());
                end
            end
            OP_MTF: begin
                for (int i = 0; i < held_words.size(); i++) begin
                    if (pos < 0 && held_words[i] == DATA_WIDTH'(beat.value)) begin
                        pos = i;
                    end
                end
                if (pos > 0) begin
                    hit = held_words[pos];
                    held_words.delete(pos);
                    held_words.push_front(hit);
                end
            end
            default: begin
            end
        endcase
        r.front_value = (held_words.size() != 0) ? FRONT_W'(held_words[0]) : '0;
        r.is_empty    = (held_words.size() == 0);
        r.entry_count = COUNT_W'(held_words.size());
        return r;
    endfunction

    function automatic int pause_cycles();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 60) begin
            return 0;
        end
        if (roll < 90) begin
            return $urandom_range(1, 3);
        end
        if (roll < 97) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(11, 30);
    endfunction

    function automatic in_beat_t random_beat(input int enq_pct, input int deq_pct);
        in_beat_t b;
        int       roll;
        roll = $urandom_range(0, 99);
        if (roll < 2) begin
            b.opcode = OP_UNUSED;
        end else if (roll < 2 + enq_pct) begin
            b.opcode = OP_ENQ;
        end else if (roll < 2 + enq_pct + deq_pct) begin
            b.opcode = OP_DEQ;
        end else begin
            b.opcode = OP_MTF;
        end
        // a small pool of words gives duplicates, so the first-match rule gets exercised
        roll = $urandom_range(0, 99);
        if (b.opcode == OP_MTF && held_words.size() != 0 && roll < 60) begin
            b.value = VALUE_W'(held_words[$urandom_range(0, held_words.size() - 1)]);
        end else if (roll < 75) begin
            b.value = VALUE_W'(word_pool[$urandom_range(0, 7)]);
        end else begin
            b.value = $urandom();
        end
        return b;
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= REPORT_CAP) begin
                $display("%0t: %s expected %h, got %h", $time, name, want, got);
            end
        end
    endfunction

    task automatic send_beat(input in_beat_t beat, input logic has_known,
                             input out_beat_t known, input bit steady);
        int gap;
        sent_notes.push_back(beat_note_t'{has_known, known});
        s_valid <= 1'b1;
        s_data  <= beat;
        do @(posedge aclk); while (!s_ready);
        gap = steady ? 0 : pause_cycles();
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    // Hold off the sender until every outstanding result is back.
    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
    endtask

    always @(posedge aclk) begin
        beat_note_t note;
        out_beat_t  want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                note = sent_notes.pop_front();
                want = apply_queue_op(s_data);
                pending_results.push_back(note.has_known ? note.known : want);
            end
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    mismatches++;
                    if (mismatches <= REPORT_CAP) begin
                        $display("%0t: result beat with none expected, expected nothing, got %p",
                                 $time, m_data);
                    end
                end else begin
                    want = pending_results.pop_front();
                    check_field("front_value", want.front_value, m_data.front_value);
                    check_field("is_empty", 32'(want.is_empty), 32'(m_data.is_empty));
                    check_field("entry_count", 32'(want.entry_count),
                                32'(m_data.entry_count));
                    check_field("status", 32'(want.status), 32'(m_data.status));
                end
            end
        end
    end

    // Result side back-pressure: short bursts of ready, occasional long stalls
    // and stretches with none at all.
    initial begin
        wait (aresetn === 1'b1);
        @(posedge aclk);
        forever begin
            m_ready <= 1'b1;
            if ($urandom_range(0, 9) < 2) begin
                repeat ($urandom_range(50, 200)) @(posedge aclk);
            end else begin
                repeat ($urandom_range(1, 8)) @(posedge aclk);
                m_ready <= 1'b0;
                repeat (1 + pause_cycles()) @(posedge aclk);
            end
        end
    end

    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned issued;
        int          phase_len;
        int          enq_pct;
        int          deq_pct;
        bit          steady;
        in_beat_t    beat;
        issued = 0;
        foreach (word_pool[k]) begin
            word_pool[k] = $urandom();
        end
        word_pool[0] = '0;
        word_pool[1] = '1;

        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int r = 0; r < NUM_DIRECTED; r++) begin
            send_beat(DIRECTED[r].beat, DIRECTED[r].has_known, DIRECTED[r].known, 1'b0);
        end
        wait_drained();

        // phases lean towards filling, draining or churning the queue
        while (issued < RANDOM_ITEMS) begin
            phase_len = $urandom_range(20, 80);
            case ($urandom_range(0, 2))
                0: begin
                    enq_pct = 70;
                    deq_pct = 14;
                end
                1: begin
                    enq_pct = 45;
                    deq_pct = 26;
                end
                default: begin
                    enq_pct = 20;
                    deq_pct = 50;
                end
            endcase
            steady = ($urandom_range(0, 4) == 0);
            if ($urandom_range(0, 4) == 0) begin
                wait_drained();
            end
            repeat (phase_len) begin
                beat = random_beat(enq_pct, deq_pct);
                send_beat(beat, 1'b0, NO_CHECK, steady);
                if (beat.opcode != OP_UNUSED) begin
                    issued++;
                end
            end
        end

        s_valid <= 1'b0;
        do @(posedge aclk); while (pending_results.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge aclk);

        if (mismatches == 0 && pending_results.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
